FILE: sv/srclip_pkg.sv
// ----------------------------------------------------------------------------
// srclip_pkg
// Shared widths and the segment record that travels through the clipper.
// ----------------------------------------------------------------------------
package srclip_pkg;

   // coordinate width, signed Q16.16 at the default of 32 bits
   localparam int W  = 32;
   // difference width, one bit wider than a coordinate
   localparam int DW = W + 1;
   // product width of two difference magnitudes
   localparam int PW = 2 * DW;
   // quotient width; a cut never moves a point past the far endpoint
   localparam int QW = DW;
   // register index width on the control port (one spare bit)
   localparam int IW = 3;
   // queue depth between front and back
   localparam int QDEPTH = 2;

   // configuration register indexes
   localparam logic [IW-1:0] REG_LEFT   = 3'd0;
   localparam logic [IW-1:0] REG_RIGHT  = 3'd1;
   localparam logic [IW-1:0] REG_BOTTOM = 3'd2;
   localparam logic [IW-1:0] REG_TOP    = 3'd3;

   // one segment in flight; dead marks an early reject
   typedef struct packed {
      logic                dead;
      logic signed [W-1:0] x0;
      logic signed [W-1:0] y0;
      logic signed [W-1:0] x1;
      logic signed [W-1:0] y1;
   } item_type;

endpackage

FILE: sv/srclip_front.sv
// ----------------------------------------------------------------------------
// srclip_front
// Takes one segment per cycle and marks those outside the bounding box.
// ----------------------------------------------------------------------------
module srclip_front
   import srclip_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic signed [W-1:0] sx,
   input  logic signed [W-1:0] sy,
   input  logic signed [W-1:0] ex,
   input  logic signed [W-1:0] ey,
   input  logic signed [W-1:0] left,
   input  logic signed [W-1:0] right,
   input  logic signed [W-1:0] bottom,
   input  logic signed [W-1:0] top,
   output logic                out_vld,
   output item_type            out_item
);

   logic                vld_ff;
   item_type            item_ff;
   item_type            item_in;
   logic signed [W-1:0] xmax, xmin, ymax, ymin;

   // bounding box reject
   always_comb begin
      xmax = (sx > ex) ? sx : ex;
      xmin = (sx < ex) ? sx : ex;
      ymax = (sy > ey) ? sy : ey;
      ymin = (sy < ey) ? sy : ey;
      item_in.dead = (xmax < left) || (xmin > right) || (ymax < bottom) || (ymin > top);
      item_in.x0 = sx;
      item_in.y0 = sy;
      item_in.x1 = ex;
      item_in.y1 = ey;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= take;
      end
      item_ff <= item_in;
   end

   assign out_vld  = vld_ff;
   assign out_item = item_ff;

endmodule

FILE: sv/srclip_fifo.sv
// ----------------------------------------------------------------------------
// srclip_fifo
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module srclip_fifo
   import srclip_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     nonempty,
   output logic     full,
   output item_type pop_item
);

   localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CW = $clog2(QDEPTH + 1);

   item_type        mem [0:QDEPTH-1];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [CW-1:0]   cnt_ff;
   logic            do_pop;

   assign do_pop   = pop && (cnt_ff != '0);
   assign nonempty = (cnt_ff != '0);
   assign full     = (cnt_ff == CW'(QDEPTH));
   assign pop_item = mem[rd_ff];

   // pointers wrap at the depth
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == AW'(QDEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == AW'(QDEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CW'(push) - CW'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_item;
      end
   end

endmodule

FILE: sv/srclip_cut.sv
// ----------------------------------------------------------------------------
// srclip_cut
// Cuts a segment at one edge: pipelined multiply, then one quotient bit per
// stage of a restoring divider, then the moved endpoint is written back.
// ----------------------------------------------------------------------------
module srclip_cut
   import srclip_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  item_type            in_item,
   input  logic signed [W-1:0] edge_pos,
   input  logic                axis_x,   // 1: edge is vertical, y is interpolated
   input  logic                move_hi,  // 1: move the endpoint with larger coordinate
   output logic                out_vld,
   output item_type            out_item
);

   // ---- stage A: classify and take magnitudes
   logic signed [W-1:0]  a0, a1, b0, b1, ap, aq, bp, bq;
   logic                 p_sel, strad;
   logic signed [DW-1:0] num, den, dv;
   logic [DW-1:0]        num_m, den_m, dv_m;

   always_comb begin
      a0 = axis_x ? in_item.x0 : in_item.y0;
      a1 = axis_x ? in_item.x1 : in_item.y1;
      b0 = axis_x ? in_item.y0 : in_item.x0;
      b1 = axis_x ? in_item.y1 : in_item.x1;
      p_sel = (!(a0 < a1)) ^ move_hi;
      ap = p_sel ? a1 : a0;
      aq = p_sel ? a0 : a1;
      bp = p_sel ? b1 : b0;
      bq = p_sel ? b0 : b1;
      strad = ((a0 < edge_pos) && (a1 > edge_pos)) || ((a0 > edge_pos) && (a1 < edge_pos));
      num = DW'(ap) - DW'(edge_pos);
      den = DW'(ap) - DW'(aq);
      dv  = DW'(bq) - DW'(bp);
      num_m = num[DW-1] ? DW'(-num) : DW'(num);
      den_m = den[DW-1] ? DW'(-den) : DW'(den);
      dv_m  = dv[DW-1]  ? DW'(-dv)  : DW'(dv);
   end

   logic          a_vld_ff, a_cut_ff, a_p_ff, a_neg_ff;
   item_type      a_item_ff;
   logic [DW-1:0] a_num_ff, a_den_ff, a_dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= in_vld;
      end
      a_item_ff <= in_item;
      a_cut_ff  <= strad && !in_item.dead;
      a_p_ff    <= p_sel;
      a_neg_ff  <= dv[DW-1];
      a_num_ff  <= num_m;
      a_den_ff  <= den_m;
      a_dv_ff   <= dv_m;
   end

   // ---- stage B: product and divider state, one register set per stage
   logic          d_vld_ff  [0:QW];
   item_type      d_item_ff [0:QW];
   logic          d_cut_ff  [0:QW];
   logic          d_p_ff    [0:QW];
   logic          d_neg_ff  [0:QW];
   logic [DW-1:0] d_den_ff  [0:QW];
   logic [DW-1:0] d_rem_ff  [0:QW];
   logic [DW-1:0] d_low_ff  [0:QW];
   logic [QW-1:0] d_quo_ff  [0:QW];
   logic [PW-1:0] prod;

   assign prod = a_dv_ff * a_num_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff[0] <= 1'b0;
      end else begin
         d_vld_ff[0] <= a_vld_ff;
      end
      d_item_ff[0] <= a_item_ff;
      d_cut_ff[0]  <= a_cut_ff;
      d_p_ff[0]    <= a_p_ff;
      d_neg_ff[0]  <= a_neg_ff;
      d_den_ff[0]  <= a_den_ff;
      d_rem_ff[0]  <= prod[PW-1:DW];
      d_low_ff[0]  <= prod[DW-1:0];
      d_quo_ff[0]  <= '0;
   end

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [DW:0] r2, r2s;
      logic        ge;
      assign r2  = {d_rem_ff[k], d_low_ff[k][DW-1]};
      assign ge  = (r2 >= {1'b0, d_den_ff[k]});
      assign r2s = ge ? (r2 - {1'b0, d_den_ff[k]}) : r2;

      always_ff @(posedge clock) begin
         if (reset) begin
            d_vld_ff[k+1] <= 1'b0;
         end else begin
            d_vld_ff[k+1] <= d_vld_ff[k];
         end
         d_item_ff[k+1] <= d_item_ff[k];
         d_cut_ff[k+1]  <= d_cut_ff[k];
         d_p_ff[k+1]    <= d_p_ff[k];
         d_neg_ff[k+1]  <= d_neg_ff[k];
         d_den_ff[k+1]  <= d_den_ff[k];
         d_rem_ff[k+1]  <= r2s[DW-1:0];
         d_low_ff[k+1]  <= {d_low_ff[k][DW-2:0], 1'b0};
         d_quo_ff[k+1]  <= {d_quo_ff[k][QW-2:0], ge};
      end
   end

   // ---- final stage: write the moved endpoint back
   item_type             f_item, fi;
   logic signed [W-1:0]  bp_f;
   logic signed [DW-1:0] moved;
   logic                 f_vld_ff;
   item_type             f_item_ff;

   always_comb begin
      fi = d_item_ff[QW];
      f_item = fi;
      if (axis_x) begin
         bp_f = d_p_ff[QW] ? fi.y1 : fi.y0;
      end else begin
         bp_f = d_p_ff[QW] ? fi.x1 : fi.x0;
      end
      moved = d_neg_ff[QW] ? (DW'(bp_f) - DW'(d_quo_ff[QW])) : (DW'(bp_f) + DW'(d_quo_ff[QW]));
      if (d_cut_ff[QW]) begin
         if (axis_x) begin
            if (d_p_ff[QW]) begin
               f_item.x1 = edge_pos;
               f_item.y1 = moved[W-1:0];
            end else begin
               f_item.x0 = edge_pos;
               f_item.y0 = moved[W-1:0];
            end
         end else begin
            if (d_p_ff[QW]) begin
               f_item.y1 = edge_pos;
               f_item.x1 = moved[W-1:0];
            end else begin
               f_item.y0 = edge_pos;
               f_item.x0 = moved[W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= d_vld_ff[QW];
      end
      f_item_ff <= f_item;
   end

   assign out_vld  = f_vld_ff;
   assign out_item = f_item_ff;

endmodule

FILE: sv/segment_rect_clipper.sv
// ----------------------------------------------------------------------------
// segment_rect_clipper
// Clips a segment against a y-up rectangle held in control registers.
// ----------------------------------------------------------------------------
// Usage: write rect_left/right/bottom/top (indexes 0..3) through csr_we,
// csr_index, csr_wdata while no segment is in flight. Present a segment on
// req_* with start high; it is taken on an edge where busy is low. One
// result per segment comes out on rsp_* marked by a one-cycle rsp_valid, in
// order; the receiver cannot hold results off.
// Throughput: one segment per cycle. From the input transfer to the result
// transfer a segment passes the four cut units in a row, each a magnitude
// stage, a multiply stage, a one-bit-per-stage divider of QW stages and a
// write-back stage, plus the front, the queue, the x recheck and the result
// register. The front (bounding box test) feeds a two-entry queue; the back
// drains it every cycle, so the queue never fills and busy stays low.
// Reset clears the rectangle to zero and empties the pipeline; no result
// is produced for items in flight at reset.
// ----------------------------------------------------------------------------
module segment_rect_clipper
   import srclip_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [W-1:0] req_start_x,
   input  logic signed [W-1:0] req_start_y,
   input  logic signed [W-1:0] req_end_x,
   input  logic signed [W-1:0] req_end_y,
   output logic                rsp_valid,
   output logic                rsp_visible,
   output logic signed [W-1:0] rsp_clip_start_x,
   output logic signed [W-1:0] rsp_clip_start_y,
   output logic signed [W-1:0] rsp_clip_end_x,
   output logic signed [W-1:0] rsp_clip_end_y,
   input  logic                csr_we,
   input  logic [IW-1:0]       csr_index,
   input  logic [W-1:0]        csr_wdata
);

   logic signed [W-1:0] left_ff, right_ff, bottom_ff, top_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         right_ff  <= '0;
         bottom_ff <= '0;
         top_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_LEFT:   left_ff   <= csr_wdata;
            REG_RIGHT:  right_ff  <= csr_wdata;
            REG_BOTTOM: bottom_ff <= csr_wdata;
            REG_TOP:    top_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front
   logic     f_vld, q_nonempty, q_full;
   item_type f_item, q_item;

   srclip_front u_front (
      .clock(clock), .reset(reset), .take(start && !busy),
      .sx(req_start_x), .sy(req_start_y), .ex(req_end_x), .ey(req_end_y),
      .left(left_ff), .right(right_ff), .bottom(bottom_ff), .top(top_ff),
      .out_vld(f_vld), .out_item(f_item)
   );

   srclip_fifo u_fifo (
      .clock(clock), .reset(reset), .push(f_vld), .push_item(f_item),
      .pop(1'b1), .nonempty(q_nonempty), .full(q_full),
      .pop_item(q_item)
   );

   assign busy = q_full;

   // y cuts
   logic     c1_vld, c2_vld, c3_vld, c4_vld;
   item_type c1_item, c2_item, c3_item, c4_item;

   srclip_cut u_cut_bottom (
      .clock(clock), .reset(reset), .in_vld(q_nonempty), .in_item(q_item),
      .edge_pos(bottom_ff), .axis_x(1'b0), .move_hi(1'b0),
      .out_vld(c1_vld), .out_item(c1_item)
   );

   srclip_cut u_cut_top (
      .clock(clock), .reset(reset), .in_vld(c1_vld), .in_item(c1_item),
      .edge_pos(top_ff), .axis_x(1'b0), .move_hi(1'b1),
      .out_vld(c2_vld), .out_item(c2_item)
   );

   // x recheck after the y cuts
   logic     r_vld_ff;
   item_type r_item_ff, r_item;
   logic signed [W-1:0] rxmax, rxmin;

   always_comb begin
      rxmax = (c2_item.x0 > c2_item.x1) ? c2_item.x0 : c2_item.x1;
      rxmin = (c2_item.x0 < c2_item.x1) ? c2_item.x0 : c2_item.x1;
      r_item = c2_item;
      r_item.dead = c2_item.dead || (rxmax < left_ff) || (rxmin > right_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
      end else begin
         r_vld_ff <= c2_vld;
      end
      r_item_ff <= r_item;
   end

   // x cuts
   srclip_cut u_cut_left (
      .clock(clock), .reset(reset), .in_vld(r_vld_ff), .in_item(r_item_ff),
      .edge_pos(left_ff), .axis_x(1'b1), .move_hi(1'b0),
      .out_vld(c3_vld), .out_item(c3_item)
   );

   srclip_cut u_cut_right (
      .clock(clock), .reset(reset), .in_vld(c3_vld), .in_item(c3_item),
      .edge_pos(right_ff), .axis_x(1'b1), .move_hi(1'b1),
      .out_vld(c4_vld), .out_item(c4_item)
   );

   // result register; rejected segments report zeros
   logic                o_vld_ff, o_vis_ff;
   logic signed [W-1:0] o_sx_ff, o_sy_ff, o_ex_ff, o_ey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else begin
         o_vld_ff <= c4_vld;
      end
      o_vis_ff <= !c4_item.dead;
      o_sx_ff  <= c4_item.dead ? '0 : c4_item.x0;
      o_sy_ff  <= c4_item.dead ? '0 : c4_item.y0;
      o_ex_ff  <= c4_item.dead ? '0 : c4_item.x1;
      o_ey_ff  <= c4_item.dead ? '0 : c4_item.y1;
   end

   assign rsp_valid        = o_vld_ff;
   assign rsp_visible      = o_vis_ff;
   assign rsp_clip_start_x = o_sx_ff;
   assign rsp_clip_start_y = o_sy_ff;
   assign rsp_clip_end_x   = o_ex_ff;
   assign rsp_clip_end_y   = o_ey_ff;

endmodule
